>>> sv/itoa_pkg.sv
package itoa_pkg;
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_FIELD   = 48;

  localparam logic [1:0] REG_RADIX  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_DIGITS = 2'd2;
  localparam logic [1:0] REG_FLAGS  = 2'd3;

  // one formatting job handed from the front to the back
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] mag;
    logic [5:0]             base;
    logic [7:0]             sign_ch;
    logic                   has_sign;
    logic [1:0]             prefix_len;
    logic                   upper;
    logic                   left;
    logic                   zero;
    logic [5:0]             width;
    logic [5:0]             mind;
    logic [7:0]             room;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] c;
    if (d < 6'd10) c = 8'h30 + {2'b00, d};
    else if (upper) c = 8'h37 + {2'b00, d};
    else c = 8'h57 + {2'b00, d};
    return c;
  endfunction
endpackage

>>> sv/itoa_front.sv
module itoa_front import itoa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [7:0]             room,
  input  logic [5:0]             radix_r,
  input  logic [5:0]             min_width_r,
  input  logic [5:0]             min_digits_r,
  input  logic [6:0]             flags_r,
  output job_t                   job_r,
  output logic                   job_vld_r,
  input  logic                   job_pop
);
  job_t job_nxt;
  logic [5:0] b;
  logic left, zero, neg;

  always_comb begin
    b = radix_r;
    if (radix_r < 6'd2) b = 6'd2;
    if (radix_r > 6'd36) b = 6'd36;
    left = flags_r[0];
    zero = flags_r[1] & ~left;
    neg  = flags_r[2] & value[VALUE_WIDTH-1];
    job_nxt.mag  = neg ? (~value + 1'b1) : value;
    job_nxt.base = b;
    job_nxt.has_sign = flags_r[2] & (neg | flags_r[3] | flags_r[4]);
    job_nxt.sign_ch = neg ? 8'h2d : (flags_r[3] ? 8'h2b : 8'h20);
    job_nxt.prefix_len = !flags_r[5] ? 2'd0 : (b == 6'd16) ? 2'd2 : (b == 6'd8) ? 2'd1 : 2'd0;
    job_nxt.upper = flags_r[6];
    job_nxt.left  = left;
    job_nxt.zero  = zero;
    job_nxt.width = (min_width_r > 6'd48) ? 6'd48 : min_width_r;
    job_nxt.mind  = (min_digits_r > 6'd32) ? 6'd32 : min_digits_r;
    job_nxt.room  = room;
  end

  // one-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) job_vld_r <= 1'b0;
    else if (take) job_vld_r <= 1'b1;
    else if (job_pop) job_vld_r <= 1'b0;
    if (take) job_r <= job_nxt;
  end
endmodule

>>> sv/itoa_divider.sv
module itoa_divider import itoa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [5:0]             divisor,
  output logic                   done_r,
  output logic [VALUE_WIDTH-1:0] quo_r,
  output logic [5:0]             rem_r
);
  // restoring division, one bit per cycle
  logic [5:0] cnt_r;
  logic       run_r;
  logic [6:0] trial;
  logic [VALUE_WIDTH-1:0] q_r;
  logic [5:0] r_r;

  assign trial = {r_r, q_r[VALUE_WIDTH-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !go && run_r && (cnt_r == '0);
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 6'(VALUE_WIDTH - 1);
      end else if (run_r) begin
        if (cnt_r == '0) run_r <= 1'b0;
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (go) begin
      q_r <= dividend;
      r_r <= '0;
    end else if (run_r) begin
      if (!trial[6]) begin
        r_r <= trial[5:0];
        q_r <= {q_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        r_r <= {r_r[4:0], q_r[VALUE_WIDTH-1]};
        q_r <= {q_r[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end
  assign quo_r = q_r;
  assign rem_r = r_r;
endmodule

>>> sv/itoa_back.sv
module itoa_back import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       job,
  input  logic       job_vld,
  output logic       job_pop,
  output logic       out_vld_r,
  output logic [7:0] out_char_r,
  output logic       out_fits_r,
  output logic       out_last_r
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_PLAN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [2:0] P_LPAD = 3'd0;
  localparam logic [2:0] P_SIGN = 3'd1;
  localparam logic [2:0] P_PRE0 = 3'd2;
  localparam logic [2:0] P_PREX = 3'd3;
  localparam logic [2:0] P_ZPAD = 3'd4;
  localparam logic [2:0] P_DIG  = 3'd5;
  localparam logic [2:0] P_RPAD = 3'd6;
  localparam logic [2:0] P_DONE = 3'd7;

  logic [2:0] st_r, ph_r;
  job_t       j_r;
  logic [VALUE_WIDTH-1:0] rem_val_r;
  logic [5:0] digit_store [VALUE_WIDTH];
  logic [5:0] ndig_r;
  logic [6:0] pad_r;
  logic [5:0] lz_r;
  logic [5:0] di_r;
  logic [7:0] emit_r;
  logic       div_go, div_done;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [5:0] div_r;
  logic [5:0] dig_rd_r;
  logic [6:0] fixed;
  logic [5:0] prec;
  logic [7:0] ch;
  logic       advance, final_ch;
  logic [2:0] ph_nxt;

  itoa_divider u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(rem_val_r),
    .divisor(j_r.base), .done_r(div_done), .quo_r(div_q), .rem_r(div_r)
  );

  assign job_pop = (st_r == S_IDLE) && job_vld;
  assign div_go  = (st_r == S_DIV);
  assign prec  = (ndig_r > j_r.mind) ? ndig_r : j_r.mind;
  assign fixed = {6'd0, j_r.has_sign} + {5'd0, j_r.prefix_len} + {1'b0, prec};

  always_comb begin
    ch = 8'h20;
    unique case (ph_r) inside
      P_LPAD, P_RPAD: ch = 8'h20;
      P_SIGN: ch = j_r.sign_ch;
      P_PRE0, P_ZPAD: ch = 8'h30;
      P_PREX: ch = j_r.upper ? 8'h58 : 8'h78;
      P_DIG: ch = (lz_r != '0) ? 8'h30 : digit_char(dig_rd_r, j_r.upper);
      default: ch = 8'h20;
    endcase
  end

  // next phase after current char
  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      P_LPAD: ph_nxt = (pad_r > 7'd1) ? P_LPAD : P_SIGN;
      P_SIGN: ph_nxt = P_PRE0;
      P_PRE0: ph_nxt = P_PREX;
      P_PREX: ph_nxt = P_ZPAD;
      P_ZPAD: ph_nxt = (pad_r > 7'd1) ? P_ZPAD : P_DIG;
      P_DIG:  ph_nxt = (lz_r != '0 || di_r != '0) ? P_DIG : P_RPAD;
      P_RPAD: ph_nxt = (pad_r > 7'd1) ? P_RPAD : P_DONE;
      default: ph_nxt = P_DONE;
    endcase
  end

  function automatic logic [2:0] skip(input logic [2:0] p, input job_t j, input logic [6:0] pad);
    logic [2:0] q;
    q = p;
    for (int k = 0; k < 7; k++) begin
      if ((q == P_LPAD && (pad == '0 || j.left || j.zero)) ||
          (q == P_SIGN && !j.has_sign) ||
          (q == P_PRE0 && j.prefix_len == 2'd0) ||
          (q == P_PREX && j.prefix_len != 2'd2) ||
          (q == P_ZPAD && (pad == '0 || !j.zero)) ||
          (q == P_RPAD && (pad == '0 || !j.left)))
        q = q + 3'd1;
    end
    return q;
  endfunction

  logic [2:0] ph_adv;
  logic [6:0] pad_init;
  assign pad_init = (fixed < {1'b0, j_r.width}) ? ({1'b0, j_r.width} - fixed) : '0;
  assign ph_adv   = skip(ph_nxt, j_r, (ph_nxt == ph_r) ? pad_r - 7'd1 : pad_r);
  assign advance  = (st_r == S_EMIT);
  assign final_ch = (ph_adv == P_DONE) || (emit_r == 8'(MAX_FIELD - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
      emit_r     <= '0;
      ph_r       <= P_LPAD;
    end else begin
      out_vld_r  <= (st_r == S_EMIT);
      out_last_r <= (st_r == S_EMIT) && final_ch;
      unique case (st_r)
        S_IDLE: if (job_vld) st_r <= S_DIV;
        S_DIV:  st_r <= S_WAIT;
        S_WAIT: if (div_done) st_r <= (div_q == '0 || ndig_r == 6'(VALUE_WIDTH - 1)) ?
                                      S_PLAN : S_DIV;
        S_PLAN: begin
          st_r   <= S_EMIT;
          emit_r <= '0;
          ph_r   <= skip(P_LPAD, j_r, pad_init);
        end
        S_EMIT: begin
          out_char_r <= ch;
          out_fits_r <= emit_r < j_r.room;
          emit_r     <= emit_r + 1'b1;
          ph_r       <= ph_adv;
          if (final_ch) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      j_r       <= job;
      rem_val_r <= job.mag;
      ndig_r    <= '0;
    end
    if (st_r == S_WAIT && div_done) begin
      digit_store[ndig_r[4:0]] <= div_r;
      rem_val_r <= div_q;
      ndig_r    <= ndig_r + 1'b1;
    end
    if (st_r == S_PLAN) begin
      pad_r <= pad_init;
      lz_r  <= prec - ndig_r;
      di_r  <= ndig_r - 1'b1;
      dig_rd_r <= digit_store[5'(ndig_r - 1'b1)];
    end
    if (advance) begin
      if (ph_nxt == ph_r && (ph_r == P_LPAD || ph_r == P_ZPAD || ph_r == P_RPAD))
        pad_r <= pad_r - 1'b1;
      else if (ph_nxt != ph_r) pad_r <= pad_r;
      if (ph_r == P_DIG) begin
        if (lz_r != '0) lz_r <= lz_r - 1'b1;
        else if (di_r != '0) begin
          di_r <= di_r - 1'b1;
          dig_rd_r <= digit_store[5'(di_r - 1'b1)];
        end
      end
    end
  end
endmodule

>>> sv/integer_to_ascii_formatter.sv
// digits are produced one at a time by a bit-serial divider, then the characters are emitted
// the back end formats one number at a time
// a one-entry job queue lets the next number be accepted while the back end emits
// results appear for one cycle on out_valid; the receiver cannot stall
// rst_n is synchronous active low; registers return to radix 10, all else 0
module integer_to_ascii_formatter import itoa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [7:0]             in_room,
  output logic                   out_valid,
  output logic [7:0]             out_char,
  output logic                   out_fits,
  output logic                   out_last,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  logic [5:0] radix_r, min_width_r, min_digits_r;
  logic [6:0] flags_r;
  job_t       job;
  logic       job_vld, job_pop, wr;
  logic [1:0] reg_idx;

  // config word writes
  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= 6'd10;
      min_width_r  <= '0;
      min_digits_r <= '0;
      flags_r      <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        REG_RADIX:  radix_r      <= pwdata[5:0];
        REG_WIDTH:  min_width_r  <= pwdata[5:0];
        REG_DIGITS: min_digits_r <= pwdata[5:0];
        REG_FLAGS:  flags_r      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_RADIX:  prdata = {26'd0, radix_r};
      REG_WIDTH:  prdata = {26'd0, min_width_r};
      REG_DIGITS: prdata = {26'd0, min_digits_r};
      REG_FLAGS:  prdata = {25'd0, flags_r};
      default:    prdata = '0;
    endcase
  end

  // queue full holds off new words
  assign busy = job_vld;

  itoa_front u_front (
    .clk(clk), .rst_n(rst_n), .take(start & ~busy), .value(in_value), .room(in_room),
    .radix_r(radix_r), .min_width_r(min_width_r), .min_digits_r(min_digits_r),
    .flags_r(flags_r), .job_r(job), .job_vld_r(job_vld), .job_pop(job_pop)
  );

  itoa_back u_back (
    .clk(clk), .rst_n(rst_n), .job(job), .job_vld(job_vld), .job_pop(job_pop),
    .out_vld_r(out_valid), .out_char_r(out_char), .out_fits_r(out_fits),
    .out_last_r(out_last)
  );

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_vld) else $error("pop of empty queue");
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without word");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word not queued");
endmodule
